### rtl/gap_buffer_text_editor_core_assert.svh
// ----------------------------------------------------------------------------
// Gap buffer editor assertion macros
// Shared property shapes for the editor core checks.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_TEXT_EDITOR_CORE_ASSERT_SVH
`define GAP_BUFFER_TEXT_EDITOR_CORE_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define GBTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define GBTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gbte_pkg.sv
// ----------------------------------------------------------------------------
// Gap buffer editor package
// Sizes, operation codes and result kinds of the gap buffer editor.
// ----------------------------------------------------------------------------
package gbte_pkg;

  // Store size and the number of characters shown after a cursor move.
  localparam int CAPACITY = 4096;
  localparam int WINDOW   = 10;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int WIN_W  = $clog2(WINDOW + 1);
  localparam int CNT_W  = 16;

  typedef logic [1:0]        op_t;
  typedef logic [1:0]        kind_t;
  typedef logic [7:0]        byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WIN_W-1:0]  win_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Operation codes.
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_LEFT   = 2'd2;
  localparam op_t OP_RIGHT  = 2'd3;

  // Result kinds.
  localparam kind_t KIND_DELETED  = 2'd0;
  localparam kind_t KIND_CHAR     = 2'd1;
  localparam kind_t KIND_EMPTY    = 2'd2;
  localparam kind_t KIND_OVERFLOW = 2'd3;

  localparam len_t CAP_LEN = len_t'(CAPACITY);
  localparam len_t WIN_LEN = len_t'(WINDOW);

endpackage

### rtl/gap_buffer_text_editor_core.sv
// ----------------------------------------------------------------------------
// Gap buffer text editor core
// One byte store holds the left text from the bottom and the right text
// from the top; items insert, delete, or move the cursor across the gap.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | fields
//   ---------+------------------------+--------------------------------------
//   input    | start && !busy         | in_op, in_char_in, in_count
//   result   | out_valid (one cycle)  | out_kind, out_char_out, out_deleted,
//            |                        | out_last
//
// Insert never raises busy; an overflow result shows in the cycle after the beat,
// and so does a delete count. A cursor move keeps busy high through the byte
// copies, the setup state and the window reads: one byte copy per cycle
// through the single read and single write port, then one window read per
// cycle. Each window character shows in the cycle after its read.
// Reset clears both lengths; the store is not cleared. Results cannot be stalled.
//
module gap_buffer_text_editor_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gbte_pkg::op_t       in_op,
  input  gbte_pkg::byte_t     in_char_in,
  input  gbte_pkg::cnt_t      in_count,
  output logic                out_valid,
  output gbte_pkg::kind_t     out_kind,
  output gbte_pkg::byte_t     out_char_out,
  output logic [12:0]         out_deleted,
  output logic                out_last
);

  import gbte_pkg::*;

`include "gap_buffer_text_editor_core_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COPY = 2'd1;
  localparam logic [1:0] ST_WSET = 2'd2;
  localparam logic [1:0] ST_WIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  len_t       left_r, left_nxt;
  len_t       right_r, right_nxt;
  len_t       copy_r, copy_nxt;
  logic       dir_right_r, dir_right_nxt;
  addr_t      win_addr_r, win_addr_nxt;
  win_t       win_left_r, win_left_nxt;

  // Pending copy write and window emission flags.
  logic       wr_pend_r, wr_pend_nxt;
  addr_t      wr_addr_r, wr_addr_nxt;
  logic       chr_valid_r, chr_valid_nxt;
  logic       chr_last_r, chr_last_nxt;

  // Registered non-character result.
  logic       res_valid_r, res_valid_nxt;
  kind_t      res_kind_r, res_kind_nxt;
  len_t       res_del_r, res_del_nxt;

  // Store ports.
  byte_t      mem [CAPACITY];
  byte_t      rdata_r;
  addr_t      rd_addr;
  logic       mem_we;
  addr_t      mem_wa;
  byte_t      mem_wd;

  logic       accept;
  logic       full;
  len_t       clamp_left;
  len_t       clamp_right;
  len_t       win_n;

  assign accept = start && (state_r == ST_IDLE);
  assign full   = ({1'b0, left_r} + {1'b0, right_r}) >= {1'b0, CAP_LEN};

  // Requested counts clamped to the text on each side.
  assign clamp_left  = ({{(CNT_W-LEN_W){1'b0}}, left_r} < in_count) ? left_r
                                                                    : len_t'(in_count);
  assign clamp_right = ({{(CNT_W-LEN_W){1'b0}}, right_r} < in_count) ? right_r
                                                                     : len_t'(in_count);
  assign win_n = (left_r < WIN_LEN) ? left_r : WIN_LEN;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt     = state_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    copy_nxt      = copy_r;
    dir_right_nxt = dir_right_r;
    win_addr_nxt  = win_addr_r;
    win_left_nxt  = win_left_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    chr_valid_nxt = 1'b0;
    chr_last_nxt  = 1'b0;
    res_valid_nxt = 1'b0;
    res_kind_nxt  = res_kind_r;
    res_del_nxt   = res_del_r;
    rd_addr       = win_addr_r;
    mem_we        = wr_pend_r;
    mem_wa        = wr_addr_r;
    mem_wd        = rdata_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_INSERT: begin
              if (full) begin
                res_valid_nxt = 1'b1;
                res_kind_nxt  = KIND_OVERFLOW;
                res_del_nxt   = '0;
              end else begin
                mem_we   = 1'b1;
                mem_wa   = addr_t'(left_r);
                mem_wd   = in_char_in;
                left_nxt = left_r + len_t'(1);
              end
            end
            OP_DELETE: begin
              left_nxt      = left_r - clamp_left;
              res_valid_nxt = 1'b1;
              res_kind_nxt  = KIND_DELETED;
              res_del_nxt   = clamp_left;
            end
            OP_LEFT: begin
              dir_right_nxt = 1'b0;
              copy_nxt      = clamp_left;
              state_nxt     = (clamp_left == '0) ? ST_WSET : ST_COPY;
            end
            OP_RIGHT: begin
              dir_right_nxt = 1'b1;
              copy_nxt      = clamp_right;
              state_nxt     = (clamp_right == '0) ? ST_WSET : ST_COPY;
            end
            default: ;
          endcase
        end
      end

      // One byte crosses the gap per cycle: read now, write next cycle.
      ST_COPY: begin
        wr_pend_nxt = 1'b1;
        if (dir_right_r) begin
          rd_addr     = addr_t'(CAP_LEN - right_r);
          wr_addr_nxt = addr_t'(left_r);
          left_nxt    = left_r + len_t'(1);
          right_nxt   = right_r - len_t'(1);
        end else begin
          rd_addr     = addr_t'(left_r - len_t'(1));
          wr_addr_nxt = addr_t'(CAP_LEN - right_r - len_t'(1));
          left_nxt    = left_r - len_t'(1);
          right_nxt   = right_r + len_t'(1);
        end
        copy_nxt = copy_r - len_t'(1);
        if (copy_r == len_t'(1)) begin
          state_nxt = ST_WSET;
        end
      end

      // After a copy, its last write lands in this cycle; set up the window reads or report an empty window.
      ST_WSET: begin
        if (win_n == '0) begin
          res_valid_nxt = 1'b1;
          res_kind_nxt  = KIND_EMPTY;
          res_del_nxt   = '0;
          state_nxt     = ST_IDLE;
        end else begin
          win_addr_nxt = addr_t'(left_r - win_n);
          win_left_nxt = win_t'(win_n);
          state_nxt    = ST_WIN;
        end
      end

      // Read one window character per cycle, oldest first.
      ST_WIN: begin
        rd_addr       = win_addr_r;
        chr_valid_nxt = 1'b1;
        chr_last_nxt  = (win_left_r == win_t'(1));
        win_addr_nxt  = win_addr_r + addr_t'(1);
        win_left_nxt  = win_left_r - win_t'(1);
        if (win_left_r == win_t'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Byte store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      wr_pend_r   <= 1'b0;
      chr_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      wr_pend_r   <= wr_pend_nxt;
      chr_valid_r <= chr_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    copy_r      <= copy_nxt;
    dir_right_r <= dir_right_nxt;
    win_addr_r  <= win_addr_nxt;
    win_left_r  <= win_left_nxt;
    wr_addr_r   <= wr_addr_nxt;
    chr_last_r  <= chr_last_nxt;
    res_kind_r  <= res_kind_nxt;
    res_del_r   <= res_del_nxt;
  end

  // Result ports: a window character comes straight from the read data.
  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = res_valid_r || chr_valid_r;
  assign out_kind     = chr_valid_r ? KIND_CHAR : res_kind_r;
  assign out_char_out = chr_valid_r ? rdata_r : 8'd0;
  assign out_deleted  = chr_valid_r ? 13'd0 : 13'(res_del_r);
  assign out_last     = chr_valid_r ? chr_last_r : 1'b1;

  // Checks.
  `GBTE_ASSERT_SAME(a_len_fits, clk, rst_n, 1'b1,
    (({1'b0, left_r} + {1'b0, right_r}) <= {1'b0, CAP_LEN}), "text exceeds the store")
  `GBTE_ASSERT_SAME(a_one_source, clk, rst_n, res_valid_r, !chr_valid_r,
    "two result sources at once")
  `GBTE_ASSERT_NEXT(a_move_busy, clk, rst_n,
    start && !busy && ((in_op == OP_LEFT) || (in_op == OP_RIGHT)), busy,
    "cursor move did not raise busy")
  `GBTE_ASSERT_SAME(a_not_last_char, clk, rst_n, out_valid && !out_last,
    out_kind == KIND_CHAR, "only window characters may continue")

endmodule
